@@ design/sfd_pkg.sv @@
// Package for the stereo feedback delay unit: widths, register codes, payload and
// control structs, and the saturating 1/256 scaling function.
// No dependencies; the design files refer to it by scoped names, the test files import it.
package sfd_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int DEPTH        = 32768;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int DELAY_W      = 15;
  localparam int GAIN_W       = 9;
  localparam int GAIN_SHIFT   = 8;
  localparam int DELAY_MARGIN = 8;
  localparam int PROD_W       = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W        = PROD_W + 1;
  localparam int EFF_W        = ((DELAY_W > ADDR_W) ? DELAY_W : ADDR_W) + 1;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(11025);
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST = GAIN_W'(128);
  localparam logic [GAIN_W-1:0]  DRY_RST      = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  WET_RST      = GAIN_W'(128);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_DRY      = 2'd2,
    REG_WET      = 2'd3
  } sfd_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } sfd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } sfd_out_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0]  feedback;
    logic [GAIN_W-1:0]  dry;
    logic [GAIN_W-1:0]  wet;
    logic               clear;
  } sfd_cfg_t;

  // Per-channel pipeline control from the top level
  typedef struct packed {
    logic              accept;
    logic              s1_move;
    logic              s2_move;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              live;
    logic              bypass;
    logic              zero_delay;
  } sfd_chan_ctl_t;

  // Divide by 256 rounding toward minus infinity, then clamp to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_shift(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] q;
    q = v >>> GAIN_SHIFT;
    if (q > SUM_MAX) begin
      q = SUM_MAX;
    end else if (q < SUM_MIN) begin
      q = SUM_MIN;
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

@@ design/sfd_regs.sv @@
// APB configuration registers of the stereo feedback delay unit.
// Depends on sfd_pkg; a write of the delay register raises a one-cycle clear.
module sfd_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfd_pkg::APB_AW-1:0] paddr,
  input  logic [sfd_pkg::APB_DW-1:0] pwdata,
  output logic [sfd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output sfd_pkg::sfd_cfg_t         cfg_o
);

  logic [sfd_pkg::DELAY_W-1:0] delay_q;
  logic [sfd_pkg::GAIN_W-1:0]  feedback_q;
  logic [sfd_pkg::GAIN_W-1:0]  dry_q;
  logic [sfd_pkg::GAIN_W-1:0]  wet_q;
  logic                        wr_en;
  sfd_pkg::sfd_reg_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = sfd_pkg::sfd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= sfd_pkg::DELAY_RST;
      feedback_q <= sfd_pkg::FEEDBACK_RST;
      dry_q      <= sfd_pkg::DRY_RST;
      wet_q      <= sfd_pkg::WET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfd_pkg::REG_DELAY:    delay_q    <= pwdata[sfd_pkg::DELAY_W-1:0];
        sfd_pkg::REG_FEEDBACK: feedback_q <= pwdata[sfd_pkg::GAIN_W-1:0];
        sfd_pkg::REG_DRY:      dry_q      <= pwdata[sfd_pkg::GAIN_W-1:0];
        sfd_pkg::REG_WET:      wet_q      <= pwdata[sfd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfd_pkg::REG_DELAY:    prdata = sfd_pkg::APB_DW'(delay_q);
      sfd_pkg::REG_FEEDBACK: prdata = sfd_pkg::APB_DW'(feedback_q);
      sfd_pkg::REG_DRY:      prdata = sfd_pkg::APB_DW'(dry_q);
      sfd_pkg::REG_WET:      prdata = sfd_pkg::APB_DW'(wet_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.delay    = delay_q;
  assign cfg_o.feedback = feedback_q;
  assign cfg_o.dry      = dry_q;
  assign cfg_o.wet      = wet_q;
  assign cfg_o.clear    = wr_en && (reg_idx == sfd_pkg::REG_DELAY);

endmodule

@@ design/sfd_chan.sv @@
// One channel of the delay unit: ring line memory, write-to-read bypass,
// feedback and mix multipliers over two stages, and the output sample register.
// Depends on sfd_pkg; pipeline control comes from the top level.
module sfd_chan (
  input  logic                               clk_i,
  input  sfd_pkg::sfd_chan_ctl_t             ctl_i,
  input  sfd_pkg::sfd_cfg_t                  cfg_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] sample_o
);

  logic signed [sfd_pkg::SAMPLE_W-1:0] line_mem [sfd_pkg::DEPTH];

  // stage 1
  logic signed [sfd_pkg::SAMPLE_W-1:0] in1_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] rd1_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] bdat1_q;
  logic                                live1_q;
  logic                                byp1_q;
  logic                                zero1_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] old1;
  logic signed [sfd_pkg::PROD_W-1:0]   fb_prod;
  logic signed [sfd_pkg::PROD_W-1:0]   dry_prod;
  logic signed [sfd_pkg::SAMPLE_W-1:0] store1;

  // stage 2
  logic signed [sfd_pkg::SAMPLE_W-1:0] store2_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] old2_q;
  logic signed [sfd_pkg::PROD_W-1:0]   dry2_q;
  logic                                zero2_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] wet_src;
  logic signed [sfd_pkg::PROD_W-1:0]   wet_prod;
  logic signed [sfd_pkg::SAMPLE_W-1:0] mix2;

  logic signed [sfd_pkg::SAMPLE_W-1:0] out_q;

  // Bypass wins over the memory; unwritten entries read as zero
  always_comb begin
    if (byp1_q) begin
      old1 = bdat1_q;
    end else if (live1_q) begin
      old1 = rd1_q;
    end else begin
      old1 = '0;
    end
  end

  assign fb_prod  = sfd_pkg::PROD_W'(old1) *
                    sfd_pkg::PROD_W'($signed({1'b0, cfg_i.feedback}));
  assign dry_prod = sfd_pkg::PROD_W'(in1_q) *
                    sfd_pkg::PROD_W'($signed({1'b0, cfg_i.dry}));
  assign store1   = sfd_pkg::sat_shift((sfd_pkg::SUM_W'(in1_q) <<< sfd_pkg::GAIN_SHIFT) +
                                       sfd_pkg::SUM_W'(fb_prod));

  // With zero delay the wet path hears the sample just stored
  assign wet_src  = zero2_q ? store2_q : old2_q;
  assign wet_prod = sfd_pkg::PROD_W'(wet_src) *
                    sfd_pkg::PROD_W'($signed({1'b0, cfg_i.wet}));
  assign mix2     = sfd_pkg::sat_shift(sfd_pkg::SUM_W'(dry2_q) + sfd_pkg::SUM_W'(wet_prod));

  always_ff @(posedge clk_i) begin
    if (ctl_i.s1_move) begin
      line_mem[ctl_i.wr_addr] <= store1;
    end
    if (ctl_i.accept) begin
      rd1_q <= line_mem[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      in1_q   <= sample_i;
      live1_q <= ctl_i.live;
      byp1_q  <= ctl_i.bypass;
      bdat1_q <= store1;
      zero1_q <= ctl_i.zero_delay;
    end
    if (ctl_i.s1_move) begin
      store2_q <= store1;
      old2_q   <= old1;
      dry2_q   <= dry_prod;
      zero2_q  <= zero1_q;
    end
    if (ctl_i.s2_move) begin
      out_q <= mix2;
    end
  end

  assign sample_o = out_q;

endmodule

@@ design/stereo_feedback_delay_unit.sv @@
// Top level of the stereo feedback delay unit: handshake pipeline, write position,
// fill tracking, read pointers, and the two channel datapaths.
// Depends on sfd_pkg, sfd_regs and sfd_chan.
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_ready   sfd_in_t  (left_in, right_in)
//   out_*        output     out_valid/out_ready sfd_out_t (left_out, right_out)
//   apb          input      psel/penable        delay, feedback, dry, wet gains
//
// One stereo pair enters per cycle while in_ready is high; a result passes in turn through
// the line read, the feedback/dry multiply stage, and the wet multiply and output register.
// Each line has one read and one write port per cycle; a one-entry bypass covers
// a delay of one sample. Lines need no clearing pass: after reset or a delay write
// the write position restarts at zero and entries not yet written read as zero.
// A stalled output backs up through the three stages before in_ready drops.
module stereo_feedback_delay_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sfd_pkg::sfd_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sfd_pkg::sfd_out_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::APB_AW-1:0] paddr,
  input  logic [sfd_pkg::APB_DW-1:0] pwdata,
  output logic [sfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam logic [sfd_pkg::EFF_W-1:0] LIM =
    sfd_pkg::EFF_W'(sfd_pkg::DEPTH - sfd_pkg::DELAY_MARGIN);

  sfd_pkg::sfd_cfg_t      cfg;
  sfd_pkg::sfd_chan_ctl_t ctl_l;
  sfd_pkg::sfd_chan_ctl_t ctl_r;

  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic r2, r3;
  logic accept, s1_move, s2_move;

  logic [sfd_pkg::ADDR_W-1:0] wp_q, wp_d;
  logic [sfd_pkg::ADDR_W-1:0] s1_wp_q;
  logic                       wrapped_q, wrapped_d;

  logic [sfd_pkg::EFF_W-1:0]  delay_ext, half, rlim, dl, dr;
  logic [sfd_pkg::ADDR_W-1:0] rd_l, rd_r;

  sfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline advance: output register, stage 2, stage 1
  assign r3         = !out_valid_q || out_ready_i;
  assign s2_move    = s2_valid_q && r3;
  assign r2         = !s2_valid_q || r3;
  assign s1_move    = s1_valid_q && r2;
  assign in_ready_o = !s1_valid_q || r2;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
    end else if (s2_move) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Restart the lines on a delay write; mark the lines full after one lap
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (cfg.clear) begin
      wp_d      = '0;
      wrapped_d = 1'b0;
    end else if (accept) begin
      wp_d = wp_q + 1'b1;
      if (wp_q == sfd_pkg::ADDR_W'(sfd_pkg::DEPTH - 1)) begin
        wrapped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wp_q <= wp_q;
    end
  end

  // Effective delays; the right one is clamped further by half the request
  assign delay_ext = sfd_pkg::EFF_W'(cfg.delay);
  assign half      = delay_ext >> 1;
  assign rlim      = (half > LIM) ? '0 : (LIM - half);
  assign dl        = (delay_ext < LIM) ? delay_ext : LIM;
  assign dr        = (delay_ext < rlim) ? delay_ext : rlim;
  assign rd_l      = wp_q - dl[sfd_pkg::ADDR_W-1:0];
  assign rd_r      = wp_q - dr[sfd_pkg::ADDR_W-1:0];

  always_comb begin
    ctl_l.accept     = accept;
    ctl_l.s1_move    = s1_move;
    ctl_l.s2_move    = s2_move;
    ctl_l.rd_addr    = rd_l;
    ctl_l.wr_addr    = s1_wp_q;
    ctl_l.live       = wrapped_q || (rd_l < wp_q);
    ctl_l.bypass     = s1_move && (rd_l == s1_wp_q);
    ctl_l.zero_delay = (dl == '0);
    ctl_r.accept     = accept;
    ctl_r.s1_move    = s1_move;
    ctl_r.s2_move    = s2_move;
    ctl_r.rd_addr    = rd_r;
    ctl_r.wr_addr    = s1_wp_q;
    ctl_r.live       = wrapped_q || (rd_r < wp_q);
    ctl_r.bypass     = s1_move && (rd_r == s1_wp_q);
    ctl_r.zero_delay = (dr == '0);
  end

  sfd_chan u_chan_l (
    .clk_i    (clk_i),
    .ctl_i    (ctl_l),
    .cfg_i    (cfg),
    .sample_i (in_data_i.left_in),
    .sample_o (out_data_o.left_out)
  );

  sfd_chan u_chan_r (
    .clk_i    (clk_i),
    .ctl_i    (ctl_r),
    .cfg_i    (cfg),
    .sample_i (in_data_i.right_in),
    .sample_o (out_data_o.right_out)
  );

  assign out_valid_o = out_valid_q;

  // Input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // Write position steps by one per accepted request when no delay write clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg.clear) |=> (wp_q == $past(wp_q) + 1'b1))
    else $error("write position did not advance");

  // The full-line mark only drops on a delay write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(wrapped_q) |-> $past(cfg.clear))
    else $error("line fill mark lost without a clear");

  // Zero delay reads the entry about to be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cfg.delay == '0)) |-> ((rd_l == wp_q) && (rd_r == wp_q) && !ctl_l.bypass))
    else $error("zero delay read pointer mismatch");

endmodule

@@ test/sfd_delay_checker.sv @@
`timescale 1ns / 100ps
// Checker for the stereo feedback delay unit: mirrors the register writes,
// predicts each stereo result and compares it with what the unit emits.
// Depends on sfd_pkg for widths, register codes and payload types.
module sfd_delay_checker
  import sfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  sfd_in_t             req_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  sfd_out_t            res_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic                pready_i,
  output int unsigned         outstanding_o,
  output int unsigned         errors_o
);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  sample_t            left_hist  [DEPTH];
  sample_t            right_hist [DEPTH];
  logic [ADDR_W-1:0]  head;
  logic [DELAY_W-1:0] delay_q;
  logic [GAIN_W-1:0]  feedback_q;
  logic [GAIN_W-1:0]  dry_q;
  logic [GAIN_W-1:0]  wet_q;
  sfd_out_t           due_q [$];
  sfd_out_t           want;
  int unsigned        errors;

  // a*ga + b*gb, divided by 256 toward minus infinity, clamped to the sample range
  function automatic sample_t mix_floor(input sample_t a, input logic [GAIN_W-1:0] ga,
                                        input sample_t b, input logic [GAIN_W-1:0] gb);
    longint acc;
    acc = longint'(a) * longint'(ga) + longint'(b) * longint'(gb);
    acc = acc >>> GAIN_SHIFT;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic clear_history();
    for (int i = 0; i < DEPTH; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    head = '0;
  endtask

  task automatic run_sample(input sfd_in_t req, output sfd_out_t res);
    int                span;
    int                lim;
    int                rlim;
    int                dl;
    int                dr;
    logic [ADDR_W-1:0] rl;
    logic [ADDR_W-1:0] rr;
    sample_t           old_l;
    sample_t           old_r;
    span = int'(delay_q);
    lim  = DEPTH - DELAY_MARGIN;
    // right tap shortens as the delay grows past two thirds of the line less its margin
    rlim = lim - span / 2;
    if (rlim < 0) begin
      rlim = 0;
    end
    dl = (span < lim) ? span : lim;
    dr = (span < rlim) ? span : rlim;
    rl = head - ADDR_W'(dl);
    rr = head - ADDR_W'(dr);
    old_l = left_hist[rl];
    old_r = right_hist[rr];
    left_hist[head]  = mix_floor(req.left_in, GAIN_W'(1 << GAIN_SHIFT), old_l, feedback_q);
    right_hist[head] = mix_floor(req.right_in, GAIN_W'(1 << GAIN_SHIFT), old_r, feedback_q);
    // with zero delay the wet tap sees the value just stored
    res.left_out  = mix_floor(req.left_in, dry_q, left_hist[rl], wet_q);
    res.right_out = mix_floor(req.right_in, dry_q, right_hist[rr], wet_q);
    head = head + 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_history();
      delay_q    = DELAY_RST;
      feedback_q = FEEDBACK_RST;
      dry_q      = DRY_RST;
      wet_q      = WET_RST;
      due_q.delete();
      errors     = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (sfd_reg_e'(paddr_i[APB_AW-1:2]))
          REG_DELAY: begin
            delay_q = pwdata_i[DELAY_W-1:0];
            clear_history();
          end
          REG_FEEDBACK: feedback_q = pwdata_i[GAIN_W-1:0];
          REG_DRY:      dry_q      = pwdata_i[GAIN_W-1:0];
          REG_WET:      wet_q      = pwdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        run_sample(req_data_i, want);
        due_q.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        if (due_q.size() == 0) begin
          if (errors < 10) begin
            $display("%t sfd: result with no request pending: left %0d right %0d",
                     $realtime, res_data_i.left_out, res_data_i.right_out);
          end
          errors++;
        end else begin
          want = due_q.pop_front();
          if (want.left_out !== res_data_i.left_out ||
              want.right_out !== res_data_i.right_out) begin
            if (errors < 10) begin
              $display("%t sfd: mismatch left exp %0d got %0d, right exp %0d got %0d",
                       $realtime, want.left_out, res_data_i.left_out,
                       want.right_out, res_data_i.right_out);
            end
            errors++;
          end
        end
      end
    end
    outstanding_o = due_q.size();
    errors_o      = errors;
  end

endmodule

@@ test/tb_stereo_feedback_delay_unit.sv @@
`timescale 1ns / 100ps
// Testbench top for the stereo feedback delay unit: clock, reset, register
// setup, sample stimulus and output back-pressure; sfd_delay_checker scores results.
// Depends on sfd_pkg, sfd_delay_checker and the unit itself.
module tb_stereo_feedback_delay_unit;
  import sfd_pkg::*;

  localparam int          CYCLE_LIMIT  = 40000;
  localparam int          RANDOM_PAIRS = 1340;
  localparam int          SWEEP_PAIRS  = 40;
  localparam int unsigned HOLD_CYCLES  = 240;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          PEAK         = (1 << (SAMPLE_W - 1)) - 1;
  localparam int          TROUGH       = -(1 << (SAMPLE_W - 1));

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  sfd_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  sfd_out_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              calm;
  logic              hold_request;
  int unsigned       outstanding;
  int unsigned       errors;
  int unsigned       cycles;

  stereo_feedback_delay_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sfd_delay_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid),
    .req_ready_i   (in_ready),
    .req_data_i    (in_data),
    .res_valid_i   (out_valid),
    .res_ready_i   (out_ready),
    .res_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_stereo_feedback_delay_unit: errors");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none while calm
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  function automatic sfd_in_t pair(input int l, input int r);
    sfd_in_t p;
    p.left_in  = SAMPLE_W'(l);
    p.right_in = SAMPLE_W'(r);
    return p;
  endfunction

  function automatic logic [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'(PEAK);
      1:       return SAMPLE_W'(TROUGH);
      2:       return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] any_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_W'(1 << GAIN_SHIFT);
      2:       return '1;
      default: return GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
    endcase
  endfunction

  // Short delays (at most 130) let the echo show inside most bursts; a few go long
  function automatic logic [DELAY_W-1:0] any_delay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DELAY_W'(1);
      2:       return DELAY_W'($urandom_range(2, 8));
      7:       return DELAY_W'($urandom_range(131, (1 << DELAY_W) - 1));
      default: return DELAY_W'($urandom_range(2, 130));
    endcase
  endfunction

  task automatic write_reg(input sfd_reg_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop the request, hold until every request has produced its result,
  // then load all registers
  task automatic configure(input logic [DELAY_W-1:0] span, input logic [GAIN_W-1:0] fb,
                           input logic [GAIN_W-1:0] dry, input logic [GAIN_W-1:0] wet);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    write_reg(REG_DELAY, APB_DW'(span));
    write_reg(REG_FEEDBACK, APB_DW'(fb));
    write_reg(REG_DRY, APB_DW'(dry));
    write_reg(REG_WET, APB_DW'(wet));
  endtask

  task automatic offer(input sfd_in_t p);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  initial begin
    int sent;
    int burst;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: long delay, so only the dry path shows
    offer(pair(PEAK, TROUGH));
    offer(pair(TROUGH, PEAK));
    offer(pair(0, -1));
    offer(pair(-1, 0));
    offer(pair(24'hAAAAAA, 24'h555555));
    offer(pair(24'h555555, 24'hAAAAAA));

    // one-sample delay with every gain at its top: feedback runs into saturation
    configure(DELAY_W'(1), '1, '1, '1);
    offer(pair(PEAK, TROUGH));
    offer(pair(PEAK, TROUGH));
    offer(pair(TROUGH, PEAK));
    offer(pair(1, -1));
    offer(pair(TROUGH, TROUGH));

    // zero delay: wet tap returns the value just stored
    configure('0, GAIN_W'(1 << GAIN_SHIFT), '0, GAIN_W'(1 << GAIN_SHIFT));
    offer(pair(PEAK, TROUGH));
    offer(pair(-3, 3));
    offer(pair(-1, 1));
    offer(pair(7, -7));

    // tiny dry gain: negative quotients round down
    configure(DELAY_W'(2), '0, GAIN_W'(1), '0);
    offer(pair(-1, 1));
    offer(pair(-255, 255));
    offer(pair(-256, 257));
    offer(pair(-257, -1));

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      configure(any_delay(), any_gain(), any_gain(), any_gain());
      burst = $urandom_range(100, 180);
      for (int k = 0; k < burst; k++) begin
        calm = (sent >= 600 && sent < 900);
        if (sent == 300) begin
          hold_request = 1'b1;
        end
        offer(pair(any_sample(), any_sample()));
        sent++;
      end
    end
    calm = 1'b0;

    // largest delay: both taps clamp
    configure('1, any_gain(), any_gain(), GAIN_W'(1 << GAIN_SHIFT));
    for (int k = 0; k < SWEEP_PAIRS; k++) begin
      offer(pair(any_sample(), any_sample()));
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_stereo_feedback_delay_unit: clean");
    end else begin
      $display("tb_stereo_feedback_delay_unit: errors");
    end
    $finish;
  end

endmodule
